// ===== rtl/ntc_ti_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_ti_pkg
// Shared types, constants and the calibration table for the thermistor
// table interpolator.
// ----------------------------------------------------------------------------
package ntc_ti_pkg;

	localparam int ADC_W      = 12;
	localparam int TEMP_W     = 12;
	localparam int STS_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int ROM_IDX_W  = 8;
	localparam int DIV_W      = 16;
	localparam int DCNT_W     = 4;
	localparam int NUM_W      = 17;
	localparam int OFF_W      = 18;
	localparam int SUM_W      = 19;
	localparam int TEMP_LIMIT = 2000;

	localparam logic [STS_W-1:0] STS_OK   = 2'd0;
	localparam logic [STS_W-1:0] STS_HIGH = 2'd1;
	localparam logic [STS_W-1:0] STS_LOW  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_DESC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DESC  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_TEMP  = 2'd2;

	localparam logic [TEMP_W-1:0] BASE_TEMP_RST = 12'hF38;

	typedef struct packed {
		logic load;
		logic probe;
		logic div_step;
		logic offs;
		logic fin;
	} ntc_cmd_t;

	typedef struct packed {
		logic range_err;
		logic hit;
		logic miss;
		logic span_zero;
		logic div_last;
		logic out_free;
	} ntc_sts_t;

	function automatic logic [ADC_W-1:0] rom_value(input logic [ROM_IDX_W-1:0] idx);
		logic [ADC_W-1:0] v;
		case (idx)
			8'd0:  v = 12'd380;   8'd1:  v = 12'd400;   8'd2:  v = 12'd422;
			8'd3:  v = 12'd444;   8'd4:  v = 12'd467;   8'd5:  v = 12'd491;
			8'd6:  v = 12'd516;   8'd7:  v = 12'd542;   8'd8:  v = 12'd568;
			8'd9:  v = 12'd596;   8'd10: v = 12'd625;   8'd11: v = 12'd654;
			8'd12: v = 12'd684;   8'd13: v = 12'd715;   8'd14: v = 12'd748;
			8'd15: v = 12'd781;   8'd16: v = 12'd814;   8'd17: v = 12'd849;
			8'd18: v = 12'd885;   8'd19: v = 12'd921;   8'd20: v = 12'd958;
			8'd21: v = 12'd996;   8'd22: v = 12'd1035;  8'd23: v = 12'd1075;
			8'd24: v = 12'd1115;  8'd25: v = 12'd1156;  8'd26: v = 12'd1197;
			8'd27: v = 12'd1239;  8'd28: v = 12'd1282;  8'd29: v = 12'd1325;
			8'd30: v = 12'd1369;  8'd31: v = 12'd1413;  8'd32: v = 12'd1457;
			8'd33: v = 12'd1502;  8'd34: v = 12'd1547;  8'd35: v = 12'd1592;
			8'd36: v = 12'd1638;  8'd37: v = 12'd1683;  8'd38: v = 12'd1729;
			8'd39: v = 12'd1775;  8'd40: v = 12'd1821;  8'd41: v = 12'd1866;
			8'd42: v = 12'd1912;  8'd43: v = 12'd1958;  8'd44: v = 12'd2003;
			8'd45: v = 12'd2048;  8'd46: v = 12'd2093;  8'd47: v = 12'd2137;
			8'd48: v = 12'd2181;  8'd49: v = 12'd2225;  8'd50: v = 12'd2269;
			8'd51: v = 12'd2311;  8'd52: v = 12'd2354;  8'd53: v = 12'd2396;
			8'd54: v = 12'd2437;  8'd55: v = 12'd2478;  8'd56: v = 12'd2518;
			8'd57: v = 12'd2558;  8'd58: v = 12'd2597;  8'd59: v = 12'd2635;
			8'd60: v = 12'd2673;  8'd61: v = 12'd2710;  8'd62: v = 12'd2746;
			8'd63: v = 12'd2782;  8'd64: v = 12'd2816;  8'd65: v = 12'd2851;
			8'd66: v = 12'd2884;  8'd67: v = 12'd2917;  8'd68: v = 12'd2949;
			8'd69: v = 12'd2980;  8'd70: v = 12'd3011;  8'd71: v = 12'd3041;
			8'd72: v = 12'd3070;  8'd73: v = 12'd3099;  8'd74: v = 12'd3126;
			8'd75: v = 12'd3154;  8'd76: v = 12'd3180;  8'd77: v = 12'd3206;
			8'd78: v = 12'd3231;  8'd79: v = 12'd3255;  8'd80: v = 12'd3279;
			8'd81: v = 12'd3302;  8'd82: v = 12'd3325;  8'd83: v = 12'd3347;
			8'd84: v = 12'd3368;  8'd85: v = 12'd3389;  8'd86: v = 12'd3409;
			8'd87: v = 12'd3429;  8'd88: v = 12'd3448;  8'd89: v = 12'd3466;
			8'd90: v = 12'd3484;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/ntc_ti_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntc_ti_ctrl
// Sequencer for one conversion: range check, table search, divide,
// offset and output load.
// ----------------------------------------------------------------------------
module ntc_ti_ctrl import ntc_ti_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sample_valid,
	output logic     sample_stall,
	input  ntc_sts_t sts,
	output ntc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PROBE = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_OFFS  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign sample_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_PROBE;
				end
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				if (sts.range_err) begin
					state_nx = ST_FIN;
				end else if (sts.miss || (sts.hit && sts.span_zero)) begin
					state_nx = ST_OFFS;
				end else if (sts.hit) begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = ST_OFFS;
				end
			end
			ST_OFFS: begin
				cmd.offs = 1'b1;
				state_nx = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin  = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== rtl/ntc_ti_dp.sv =====
// ----------------------------------------------------------------------------
// ntc_ti_dp
// Datapath: range check, bisection over the calibration table, restoring
// divider, offset arithmetic, clamp and result register.
// ----------------------------------------------------------------------------
module ntc_ti_dp import ntc_ti_pkg::*; #(
	parameter int TABLE_LEN = 91
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ntc_cmd_t                 cmd,
	output ntc_sts_t                 sts,
	input  logic [ADC_W-1:0]         adc_sample,
	input  logic                     table_descending,
	input  logic                     temp_descending,
	input  logic signed [TEMP_W-1:0] base_temp,
	input  logic                     result_stall,
	output logic                     result_valid,
	output logic signed [TEMP_W-1:0] temperature,
	output logic [STS_W-1:0]         range_status
);

	localparam int IDX_W   = $clog2(TABLE_LEN);
	localparam int PROBES  = $clog2(TABLE_LEN + 1);
	localparam int PCNT_W  = $clog2(PROBES + 1);
	localparam int MID10_W = $clog2(TABLE_LEN * 10);
	localparam logic [ADC_W-1:0]  FIRST_VAL   = rom_value(ROM_IDX_W'(0));
	localparam logic [ADC_W-1:0]  LAST_VAL    = rom_value(ROM_IDX_W'(TABLE_LEN - 1));
	localparam logic [IDX_W-1:0]  TOP_IDX     = IDX_W'(TABLE_LEN - 1);
	localparam logic [IDX_W:0]    LEN_IDX     = (IDX_W + 1)'(TABLE_LEN);
	localparam logic [PCNT_W-1:0] PROBES_INIT = PCNT_W'(PROBES);
	localparam logic [DCNT_W-1:0] DCNT_LAST   = DCNT_W'(DIV_W - 1);

	logic [ADC_W-1:0]        src_q;
	logic [STS_W-1:0]        status_q;
	logic [IDX_W-1:0]        lo_q;
	logic [IDX_W-1:0]        hi_q;
	logic [PCNT_W-1:0]       pcnt_q;
	logic [IDX_W-1:0]        mid_q;
	logic                    neg_q;
	logic [ADC_W-1:0]        dvs_q;
	logic [ADC_W-1:0]        rem_q;
	logic [DIV_W-1:0]        quo_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic signed [OFF_W-1:0] offset_q;
	logic                    res_valid_q;
	logic [TEMP_W-1:0]       res_temp_q;
	logic [STS_W-1:0]        res_status_q;

	logic [STS_W-1:0]        range_nx;
	logic [IDX_W:0]          mid_sum;
	logic [IDX_W-1:0]        mid;
	logic [IDX_W:0]          nxt;
	logic [ADC_W-1:0]        k_val;
	logic [ADC_W-1:0]        l_val;
	logic                    below;
	logic                    above;
	logic                    probing;
	logic                    hit;
	logic signed [ADC_W:0]   diff;
	logic signed [ADC_W:0]   span;
	logic signed [NUM_W-1:0] num_ext;
	logic signed [NUM_W-1:0] num;
	logic [NUM_W-1:0]        num_neg;
	logic [ADC_W:0]          span_neg;
	logic [DIV_W-1:0]        num_mag;
	logic [ADC_W-1:0]        span_mag;
	logic [ADC_W:0]          shifted;
	logic [ADC_W:0]          trial;
	logic                    ge;
	logic signed [NUM_W-1:0] frac;
	logic [MID10_W-1:0]      mid10;
	logic signed [OFF_W-1:0] offset_nx;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] clamped;
	logic [TEMP_W-1:0]       temp_nx;

	always_comb begin
		range_nx = STS_OK;
		if (table_descending) begin
			if (adc_sample > FIRST_VAL) begin
				range_nx = STS_HIGH;
			end else if (adc_sample < LAST_VAL) begin
				range_nx = STS_LOW;
			end
		end else begin
			if (adc_sample < FIRST_VAL) begin
				range_nx = STS_LOW;
			end else if (adc_sample > LAST_VAL) begin
				range_nx = STS_HIGH;
			end
		end
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IDX_W:1];
	assign nxt     = {1'b0, mid} + {{IDX_W{1'b0}}, 1'b1};
	assign k_val   = rom_value(ROM_IDX_W'(mid));
	assign l_val   = (nxt >= LEN_IDX) ? '0 : rom_value(ROM_IDX_W'(nxt));
	assign below   = table_descending ? (src_q <= k_val) : (k_val <= src_q);
	assign above   = table_descending ? (src_q >= l_val) : (l_val >= src_q);
	assign probing = (lo_q <= hi_q) && (pcnt_q != '0);
	assign hit     = probing && below && above;

	assign diff     = $signed({1'b0, src_q}) - $signed({1'b0, k_val});
	assign span     = $signed({1'b0, l_val}) - $signed({1'b0, k_val});
	assign num_ext  = {{(NUM_W - ADC_W - 1){diff[ADC_W]}}, diff};
	assign num      = num_ext * 17'sd10;
	assign num_neg  = -num;
	assign span_neg = -span;
	assign num_mag  = num[NUM_W-1] ? num_neg[DIV_W-1:0] : num[DIV_W-1:0];
	assign span_mag = span[ADC_W] ? span_neg[ADC_W-1:0] : span[ADC_W-1:0];

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign ge      = (shifted >= {1'b0, dvs_q});
	assign trial   = shifted - {1'b0, dvs_q};

	assign frac      = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign mid10     = MID10_W'(mid_q * 10);
	assign offset_nx = $signed({frac[NUM_W-1], frac})
	                 + $signed({{(OFF_W - MID10_W){1'b0}}, mid10});

	always_comb begin
		if (temp_descending) begin
			sum = $signed({{(SUM_W - TEMP_W){base_temp[TEMP_W-1]}}, base_temp})
			    - $signed({offset_q[OFF_W-1], offset_q});
		end else begin
			sum = $signed({{(SUM_W - TEMP_W){base_temp[TEMP_W-1]}}, base_temp})
			    + $signed({offset_q[OFF_W-1], offset_q});
		end
		if (sum > SUM_W'(TEMP_LIMIT)) begin
			clamped = SUM_W'(TEMP_LIMIT);
		end else if (sum < -SUM_W'(TEMP_LIMIT)) begin
			clamped = -SUM_W'(TEMP_LIMIT);
		end else begin
			clamped = sum;
		end
		temp_nx = (status_q != STS_OK) ? '0 : clamped[TEMP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q    <= adc_sample;
			status_q <= range_nx;
			lo_q     <= '0;
			hi_q     <= TOP_IDX;
			pcnt_q   <= PROBES_INIT;
		end
		if (cmd.probe) begin
			if (!probing) begin
				mid_q <= '0;
				quo_q <= '0;
				neg_q <= 1'b0;
			end else if (hit) begin
				mid_q  <= mid;
				quo_q  <= (span == '0) ? '0 : num_mag;
				neg_q  <= num[NUM_W-1] ^ span[ADC_W];
				dvs_q  <= span_mag;
				rem_q  <= '0;
				dcnt_q <= '0;
			end else begin
				pcnt_q <= pcnt_q - 1'b1;
				if (below) begin
					lo_q <= mid;
				end else begin
					hi_q <= mid;
				end
			end
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? trial[ADC_W-1:0] : shifted[ADC_W-1:0];
			quo_q  <= {quo_q[DIV_W-2:0], ge};
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.offs) begin
			offset_q <= offset_nx;
		end
		if (cmd.fin) begin
			res_temp_q   <= temp_nx;
			res_status_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign sts.range_err = (status_q != STS_OK);
	assign sts.hit       = hit;
	assign sts.miss      = !probing;
	assign sts.span_zero = (span == '0);
	assign sts.div_last  = (dcnt_q == DCNT_LAST);
	assign sts.out_free  = !res_valid_q || !result_stall;

	assign result_valid = res_valid_q;
	assign temperature  = $signed(res_temp_q);
	assign range_status = res_status_q;

endmodule

// ===== rtl/ntc_table_interpolate.sv =====
// ----------------------------------------------------------------------------
// ntc_table_interpolate
// Thermistor converter sample to temperature in tenths of a degree.
//
// A sample transaction (sample_valid, sample_stall, adc_sample) is taken
// when sample_valid is high and sample_stall low. The block works on one
// sample at a time: the accepting edge captures and range checks it, then
// up to clog2(TABLE_LEN+1) bisection probes over the calibration table (7 for
// 91 entries), the bit-serial divider when the bracketing entries differ,
// the offset step and the load of the result register. The next sample
// is taken the cycle after the result loads, even while that result
// still waits. Out of range samples skip search, divide and offset.
// Results leave on (result_valid, result_stall, temperature,
// range_status); a stalled result holds, and a finished item waits in the
// sequencer until the result register is free. Configuration writes
// (cfg_valid, cfg_ready, cfg_index, cfg_data) are always ready; reset
// restores ascending order and a base of -20.0 degrees.
// ----------------------------------------------------------------------------
module ntc_table_interpolate import ntc_ti_pkg::*; #(
	parameter int TABLE_LEN = 91
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  logic [ADC_W-1:0]         adc_sample,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [TEMP_W-1:0] temperature,
	output logic [STS_W-1:0]         range_status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	logic                     table_desc_q;
	logic                     temp_desc_q;
	logic signed [TEMP_W-1:0] base_temp_q;
	ntc_cmd_t                 cmd;
	ntc_sts_t                 sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_desc_q <= 1'b0;
			temp_desc_q  <= 1'b0;
			base_temp_q  <= BASE_TEMP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TABLE_DESC: table_desc_q <= cfg_data[0];
				CFG_TEMP_DESC:  temp_desc_q  <= cfg_data[0];
				CFG_BASE_TEMP:  base_temp_q  <= $signed(cfg_data[TEMP_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	ntc_ti_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	ntc_ti_dp #(
		.TABLE_LEN (TABLE_LEN)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.adc_sample       (adc_sample),
		.table_descending (table_desc_q),
		.temp_descending  (temp_desc_q),
		.base_temp        (base_temp_q),
		.result_stall     (result_stall),
		.result_valid     (result_valid),
		.temperature      (temperature),
		.range_status     (range_status)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (range_status != STS_OK)) |-> (temperature == '0))
		else $error("range error result carries a non-zero temperature");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (range_status == STS_OK || range_status == STS_HIGH
			|| range_status == STS_LOW))
		else $error("undefined range status");

	a_temp_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (temperature <= TEMP_W'(TEMP_LIMIT)
			&& temperature >= -TEMP_W'(TEMP_LIMIT)))
		else $error("temperature outside the clamp limits");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("second sample taken while one is in progress");

endmodule
